// ===== rtl/csrct_pkg.sv =====
// Shared types, byte codes and constants for the CSI status-row clobber tracker.
package csrct_pkg;

  localparam int unsigned RowWidth = 16;
  localparam int unsigned NumWidth = RowWidth + 4;

  localparam logic [RowWidth-1:0] RowsReset = RowWidth'(24);
  localparam logic [RowWidth-1:0] RowOne    = RowWidth'(1);
  localparam logic [RowWidth-1:0] RowMax    = {RowWidth{1'b1}};

  // Byte codes of interest
  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;  // [
  localparam logic [7:0] ChJ     = 8'h4A;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChF     = 8'h66;  // f
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    OpByte    = 2'd0,
    OpSetRow  = 2'd1,
    OpClrFlag = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PhGround = 2'd0,
    PhEsc    = 2'd1,
    PhCsi    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  byte_value;
    logic [15:0] row_value;
  } item_t;

  typedef struct packed {
    phase_e              phase;
    logic [1:0]          param_len;
    logic [7:0]          first_param;
    logic [RowWidth-1:0] num_accum;
    logic                num_seen;
    logic                num_closed;
    logic [RowWidth-1:0] row;
    logic                flag;
  } track_state_t;

  typedef struct packed {
    logic        bar_clobbered;
    logic        bar_needs_repaint;
    logic [15:0] tracked_row;
  } result_t;

endpackage

// ===== rtl/csrct_if.sv =====
// Valid/ready channel interfaces for the tracker's input and result beats.
interface csrct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  byte_value;
  logic [15:0] row_value;
  logic        chunk_end;

  modport source (output valid, op, byte_value, row_value, chunk_end, input ready);
  modport sink   (input valid, op, byte_value, row_value, chunk_end, output ready);
endinterface

interface csrct_out_if;
  logic        valid;
  logic        ready;
  logic        bar_clobbered;
  logic        bar_needs_repaint;
  logic [15:0] tracked_row;

  modport source (output valid, bar_clobbered, bar_needs_repaint, tracked_row, input ready);
  modport sink   (input valid, bar_clobbered, bar_needs_repaint, tracked_row, output ready);
endinterface

// ===== rtl/csi_status_row_clobber_tracker.sv =====
// Top level of the CSI status-row clobber tracker.
//
// Watches a terminal output byte stream for ESC [ sequences, tracks the
// one-based cursor row and raises a sticky repaint flag when a sequence may
// have overwritten the bottom status row. Every input beat (op 0 byte, op 1
// set row, op 2 clear flag) yields exactly one result beat carrying the
// clobber hit for that beat, the repaint flag and the tracked row after it.
// Throughput is one beat per clock while the result side drains; a full,
// stalled result register holds the input. An accepted beat passes the input
// register, then one combinational parse step into the result register.
// The input side keeps accepting while a result waits, as long as the result
// register drains in the same cycle. screen_rows is written through
// cfg_we_i/cfg_data_i; the user must write it only while idle, as the block
// does not enforce this. Reset value 24, and 0 turns off row tracking.
// chunk_end is carried on the channel but has no effect on behavior.
module csi_status_row_clobber_tracker import csrct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  csrct_in_if.sink           item_i,
  csrct_out_if.source        result_o
);

  // input register
  logic         in_vld_q;
  item_t        in_item_q;
  // tracker state and config
  track_state_t st_q;
  track_state_t st_d;
  logic [RowWidth-1:0] rows_q;
  // result register
  logic         out_vld_q;
  result_t      out_res_q;

  logic         hit;
  logic         advance;
  logic         in_fire;

  // the registered item moves into the result register when it has room
  assign advance      = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || advance;
  assign in_fire      = item_i.valid && item_i.ready;

  csrct_step u_step (
    .item_i  (in_item_q),
    .state_i (st_q),
    .rows_i  (rows_q),
    .state_o (st_d),
    .hit_o   (hit)
  );

  // control: valid bits, tracker state, config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PhGround, param_len: 2'd0, first_param: '0,
                     num_accum: '0, num_seen: 1'b0, num_closed: 1'b0,
                     row: '0, flag: 1'b0};
      rows_q    <= RowsReset;
    end else begin
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      if (advance) begin
        st_q      <= st_d;
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        rows_q <= cfg_data_i[RowWidth-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= '{op: item_i.op, byte_value: item_i.byte_value,
                     row_value: item_i.row_value};
    end
    if (advance) begin
      out_res_q <= '{bar_clobbered: hit, bar_needs_repaint: st_d.flag,
                     tracked_row: 16'(st_d.row)};
    end
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.bar_clobbered     = out_res_q.bar_clobbered;
  assign result_o.bar_needs_repaint = out_res_q.bar_needs_repaint;
  assign result_o.tracked_row       = out_res_q.tracked_row;

endmodule

// ===== rtl/csrct_step.sv =====
// One-beat parse step: next tracker state and clobber hit for a registered item.
module csrct_step import csrct_pkg::*; (
  input  item_t               item_i,
  input  track_state_t        state_i,
  input  logic [RowWidth-1:0] rows_i,
  output track_state_t        state_o,
  output logic                hit_o
);

  logic                rows_nz;
  logic [7:0]          c;
  logic                is_digit;
  logic                is_param;
  logic                one;
  logic [7:0]          p;
  logic                j_all;
  logic                k_all;
  logic [RowWidth-1:0] lead;
  logic [RowWidth-1:0] up_row;
  logic [RowWidth:0]   dn_sum;
  logic [RowWidth-1:0] dn_row;
  logic [NumWidth-1:0] num_next;
  logic [RowWidth:0]   row_inc;
  logic                do_ground;

  assign c        = item_i.byte_value;
  assign rows_nz  = (rows_i != '0);
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign is_param = is_digit || (c == ChSemi) || (c == ChQmark);
  assign one      = (state_i.param_len == 2'd1);
  assign p        = state_i.first_param;

  assign j_all = (c == ChJ) && ((state_i.param_len == 2'd0) ||
                 (one && ((p == ChZero) || (p == ChTwo) || (p == ChThree))));
  assign k_all = (c == ChK) && ((state_i.param_len == 2'd0) ||
                 (one && ((p == ChZero) || (p == ChTwo))));

  assign lead   = state_i.num_seen ? state_i.num_accum : RowOne;
  assign up_row = (state_i.row <= lead) ? RowOne : (state_i.row - lead);
  assign dn_sum = {1'b0, state_i.row} + {1'b0, lead};
  assign dn_row = (dn_sum > {1'b0, rows_i}) ? rows_i : dn_sum[RowWidth-1:0];

  // accum * 10 + digit, as shift-add
  assign num_next = NumWidth'({state_i.num_accum, 3'b000})
                  + NumWidth'({state_i.num_accum, 1'b0})
                  + NumWidth'(c - ChZero);

  assign row_inc = {1'b0, state_i.row} + (RowWidth+1)'(1);

  always_comb begin
    state_o   = state_i;
    hit_o     = 1'b0;
    do_ground = 1'b0;

    unique case (op_e'(item_i.op))
      OpByte: begin
        unique case (state_i.phase)
          PhEsc: begin
            if (c == ChLbr) begin
              state_o.phase       = PhCsi;
              state_o.param_len   = 2'd0;
              state_o.first_param = '0;
              state_o.num_accum   = '0;
              state_o.num_seen    = 1'b0;
              state_o.num_closed  = 1'b0;
            end else begin
              state_o.phase = PhGround;
              do_ground     = 1'b1;
            end
          end
          PhCsi: begin
            if (is_param) begin
              if (state_i.param_len == 2'd0) begin
                state_o.first_param = c;
              end
              if (state_i.param_len != 2'd2) begin
                state_o.param_len = state_i.param_len + 2'd1;
              end
              if (!state_i.num_closed && is_digit) begin
                state_o.num_accum = (num_next[NumWidth-1:RowWidth] != '0) ?
                                    RowMax : num_next[RowWidth-1:0];
                state_o.num_seen  = 1'b1;
              end else begin
                state_o.num_closed = 1'b1;
              end
            end else begin
              // final byte: run its action, then rescan it as a plain byte
              priority if (j_all || k_all) begin
                hit_o = 1'b1;
              end else if (one && (p == ChOne) && ((c == ChJ) || (c == ChK))) begin
                hit_o = rows_nz && (state_i.row == rows_i);
              end else if (((c == ChH) || (c == ChF)) && rows_nz) begin
                state_o.row = lead;
                hit_o       = (lead == rows_i);
              end else if ((c == ChA) && rows_nz) begin
                state_o.row = up_row;
                hit_o       = (up_row == rows_i);
              end else if ((c == ChB) && rows_nz) begin
                state_o.row = dn_row;
                hit_o       = (dn_row == rows_i);
              end else begin
                hit_o = 1'b0;
              end
              state_o.flag  = state_i.flag | hit_o;
              state_o.phase = PhGround;
              do_ground     = 1'b1;
            end
          end
          default: begin
            state_o.phase = PhGround;
            do_ground     = 1'b1;
          end
        endcase

        // Plain-byte scan. A final byte that moved the row is never LF,
        // so the pre-update row is the right one to test here.
        if (do_ground) begin
          if ((c == ChLf) && rows_nz && (row_inc < {1'b0, rows_i})) begin
            state_o.row = row_inc[RowWidth-1:0];
          end else if (c == ChEsc) begin
            state_o.phase = PhEsc;
          end
        end
      end
      OpSetRow:  state_o.row  = item_i.row_value[RowWidth-1:0];
      OpClrFlag: state_o.flag = 1'b0;
      default: ;
    endcase
  end

endmodule

// ===== rtl/csrct_checker.sv =====
// Port-level checks for the clobber tracker, bound onto the top level.
module csrct_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_clobbered_i,
  input logic        out_repaint_i,
  input logic [15:0] out_row_i
);

  // a waiting result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a waiting result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_clobbered_i) && $stable(out_repaint_i)
                                    && $stable(out_row_i))
    else $error("result payload changed while stalled");

  // a hit always leaves the sticky flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_clobbered_i |-> out_repaint_i)
    else $error("clobber reported without repaint flag");

  // accepted beat with a draining sink comes out of the result register as a valid beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("result beat missing after accept");

endmodule

bind csi_status_row_clobber_tracker csrct_assert u_csrct_assert (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (item_i.valid),
  .in_ready_i      (item_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .out_clobbered_i (result_o.bar_clobbered),
  .out_repaint_i   (result_o.bar_needs_repaint),
  .out_row_i       (result_o.tracked_row)
);

// ===== tb/csrct_checker.sv =====
// Checker for the tracker: follows both channels, predicts each result beat and compares.
`timescale 1ns / 1ps
module csrct_checker import csrct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  csrct_in_if         item_mon,
  csrct_out_if        result_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned reports_due_o
);

  // Predicted tracker state
  logic [15:0] rows_q;
  phase_e      phase_q;
  logic [1:0]  plen_q;
  logic [7:0]  first_q;
  logic [15:0] accum_q;
  logic        seen_q;
  logic        closed_q;
  logic [15:0] row_q;
  logic        flag_q;

  // Results still owed by the block, oldest first
  result_t pending_reports[$];

  // Byte seen outside a sequence: line feed moves down, ESC opens a sequence.
  function automatic void plain_byte(logic [7:0] c);
    if (c == ChLf && rows_q != '0 && 32'(row_q) + 1 < 32'(rows_q)) begin
      row_q = row_q + 16'd1;
    end else if (c == ChEsc) begin
      phase_q = PhEsc;
    end
  endfunction

  function automatic result_t advance_tracker(logic [1:0] op, logic [7:0] c,
                                              logic [15:0] row_val);
    result_t     res;
    logic        hit;
    logic        one;
    logic [15:0] n;
    int unsigned acc;
    hit = 1'b0;
    case (op)
      OpByte: begin
        if (phase_q == PhEsc) begin
          if (c == ChLbr) begin
            phase_q  = PhCsi;
            plen_q   = '0;
            first_q  = '0;
            accum_q  = '0;
            seen_q   = 1'b0;
            closed_q = 1'b0;
          end else begin
            phase_q = PhGround;
            plain_byte(c);
          end
        end else if (phase_q == PhCsi &&
                     ((c >= ChZero && c <= ChNine) || c == ChSemi || c == ChQmark)) begin
          if (plen_q == 2'd0) first_q = c;
          if (plen_q != 2'd2) plen_q = plen_q + 2'd1;
          if (!closed_q && c >= ChZero && c <= ChNine) begin
            acc     = 32'(accum_q) * 10 + 32'(c - ChZero);
            accum_q = (acc > 32'(RowMax)) ? RowMax : acc[15:0];
            seen_q  = 1'b1;
          end else begin
            closed_q = 1'b1;
          end
        end else if (phase_q == PhCsi) begin
          one = (plen_q == 2'd1);
          n   = seen_q ? accum_q : RowOne;
          if (c == ChJ && (plen_q == 2'd0 ||
              (one && (first_q == ChZero || first_q == ChTwo || first_q == ChThree)))) begin
            hit = 1'b1;
          end else if (c == ChK && (plen_q == 2'd0 ||
                       (one && (first_q == ChZero || first_q == ChTwo)))) begin
            hit = 1'b1;
          end else if (one && first_q == ChOne && (c == ChJ || c == ChK)) begin
            hit = (rows_q != '0) && (row_q == rows_q);
          end else if ((c == ChH || c == ChF) && rows_q != '0) begin
            row_q = n;
            hit   = (row_q == rows_q);
          end else if ((c == ChA || c == ChB) && rows_q != '0) begin
            if (c == ChA) begin
              row_q = (row_q <= n) ? RowOne : row_q - n;
            end else begin
              row_q = (17'(row_q) + 17'(n) > 17'(rows_q)) ? rows_q : row_q + n;
            end
            hit = (row_q == rows_q);
          end
          if (hit) flag_q = 1'b1;
          // final byte gets a second look as a plain byte
          phase_q = PhGround;
          plain_byte(c);
        end else begin
          phase_q = PhGround;
          plain_byte(c);
        end
      end
      OpSetRow:  row_q = row_val;
      OpClrFlag: flag_q = 1'b0;
      default: ;
    endcase
    res.bar_clobbered     = hit;
    res.bar_needs_repaint = flag_q;
    res.tracked_row       = row_q;
    return res;
  endfunction

  // Sampled on the falling edge: all drivers move on the rising edge, so what is
  // seen here is exactly what the next rising edge will accept.
  always @(negedge clk_i or negedge rst_ni) begin : monitor
    result_t due;
    result_t owed;
    if (!rst_ni) begin
      rows_q         = RowsReset;
      phase_q        = PhGround;
      plen_q         = '0;
      first_q        = '0;
      accum_q        = '0;
      seen_q         = 1'b0;
      closed_q       = 1'b0;
      row_q          = '0;
      flag_q         = 1'b0;
      pending_reports.delete();
      mismatch_cnt_o = 0;
      reports_due_o  = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (pending_reports.size() == 0) begin
          $error("result beat with nothing outstanding");
          mismatch_cnt_o++;
        end else begin
          due = pending_reports.pop_front();
          if (result_mon.bar_clobbered !== due.bar_clobbered) begin
            $error("bar_clobbered: expected %0d, got %0d",
                   due.bar_clobbered, result_mon.bar_clobbered);
            mismatch_cnt_o++;
          end
          if (result_mon.bar_needs_repaint !== due.bar_needs_repaint) begin
            $error("bar_needs_repaint: expected %0d, got %0d",
                   due.bar_needs_repaint, result_mon.bar_needs_repaint);
            mismatch_cnt_o++;
          end
          if (result_mon.tracked_row !== due.tracked_row) begin
            $error("tracked_row: expected %0d, got %0d",
                   due.tracked_row, result_mon.tracked_row);
            mismatch_cnt_o++;
          end
        end
      end
      if (cfg_we_i) rows_q = cfg_data_i;
      if (item_mon.valid && item_mon.ready) begin
        owed = advance_tracker(item_mon.op, item_mon.byte_value, item_mon.row_value);
        pending_reports.insert(pending_reports.size(), owed);
      end
      reports_due_o = pending_reports.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the status-row clobber tracker: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps
module tb_top;
  import csrct_pkg::*;

  // op 3 is not defined; the block must leave its state alone
  localparam logic [1:0]  OpUnused    = 2'd3;
  // cycles without any accepted beat before the run is declared hung
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned NumSegments = 7;
  localparam int unsigned SegItems    = 250;
  // margin to catch stray result beats
  localparam int unsigned DrainCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  csrct_in_if  item_ch ();
  csrct_out_if result_ch ();

  int unsigned mismatches;
  int unsigned reports_due;

  // percent chance per cycle that the sender holds off / the receiver stalls
  int unsigned send_idle_pct = 20;
  int unsigned recv_idle_pct = 77;
  // screen height the block is currently set to; steers random row values
  int unsigned rows_now      = 24;
  int unsigned items_sent    = 0;

  csi_status_row_clobber_tracker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch),
    .result_o   (result_ch)
  );

  csrct_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .item_mon       (item_ch),
    .result_mon     (result_ch),
    .mismatch_cnt_o (mismatches),
    .reports_due_o  (reports_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure: a fresh coin each cycle, so stalls land on every
  // phase of the block's pipeline.
  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hang detector: any accepted beat on either side resets the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // One input beat. Optional hold-off first, then valid stays up until the
  // beat is taken. valid is never dropped and raised in the same step: it is
  // only lowered when a hold-off cycle is actually inserted.
  task automatic send_item(input logic [1:0] op, input logic [7:0] value,
                           input logic [15:0] row_val, input logic last);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.byte_value <= value;
    item_ch.row_value  <= row_val;
    item_ch.chunk_end  <= last;
    // ready is stable between the falling edge and the next rising edge
    do begin
      @(negedge clk_i);
      taken = item_ch.ready;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // Output byte; the unused row field and chunk_end carry noise.
  task automatic send_byte(input logic [7:0] value);
    send_item(OpByte, value, 16'($urandom), 1'($urandom));
  endtask

  // ESC [ <params> <final>
  task automatic send_csi(input string params, input logic [7:0] fin);
    send_byte(ChEsc);
    send_byte(ChLbr);
    for (int i = 0; i < params.len(); i++) send_byte(params[i]);
    send_byte(fin);
  endtask

  // Numbers clustered around the screen height, where the bottom-row
  // comparisons and the clamps live.
  function automatic int unsigned near_rows();
    case ($urandom_range(0, 5))
      0:       return rows_now;
      1:       return rows_now - 1;  // wraps huge when rows is 0: saturates in the block
      2:       return rows_now + 1;
      3:       return 0;
      4:       return 1;
      default: return $urandom_range(0, rows_now + 2);
    endcase
  endfunction

  // Register write only with the block drained; every item gives exactly one
  // result, so an empty expectation list means the pipeline is empty.
  task automatic write_rows(input logic [15:0] value);
    item_ch.valid <= 1'b0;
    while (reports_due != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    rows_now    = value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly well-formed sequences with random content; the rest is bare line
  // feeds, lone ESCs, raw noise bytes and the non-byte operations.
  task automatic send_random_burst();
    int unsigned pick;
    string       params;
    logic [7:0]  fin;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        0, 1:       params = "";
        2, 3, 4, 5: params = $sformatf("%0d", near_rows());
        6:          params = $sformatf("%0d", $urandom_range(0, 3));  // erase selectors
        7:          params = {"?", $sformatf("%0d", near_rows())};
        8:          params = $sformatf("%0d;%0d", near_rows(), $urandom_range(0, 99));
        default:    params = $sformatf("%0d", $urandom_range(65530, 999999));  // overflow
      endcase
      case ($urandom_range(0, 11))
        0:       fin = ChJ;
        1:       fin = ChK;
        2:       fin = ChH;
        3:       fin = ChF;
        4, 5:    fin = ChA;
        6, 7:    fin = ChB;
        8:       fin = ChEsc;  // ends the sequence and opens the next one
        9:       fin = ChLf;   // ends the sequence and still moves the cursor
        default: fin = 8'($urandom);
      endcase
      send_csi(params, fin);
    end else if (pick < 67) begin
      send_byte(ChLf);
    end else if (pick < 75) begin
      send_byte(ChEsc);
      send_byte(8'($urandom));
    end else if (pick < 85) begin
      send_byte(8'($urandom));
    end else if (pick < 93) begin
      send_item(OpSetRow, 8'($urandom),
                $urandom_range(0, 1) ? 16'(near_rows()) : 16'($urandom), 1'($urandom));
    end else if (pick < 98) begin
      send_item(OpClrFlag, 8'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      send_item(OpUnused, 8'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned seg_rows [NumSegments];
    int unsigned target;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_data_i         <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.op         <= OpByte;
    item_ch.byte_value <= '0;
    item_ch.row_value  <= '0;
    item_ch.chunk_end  <= 1'b0;

    // screen heights per segment: reset value, both extremes, tiny screens
    seg_rows = '{24, 0, 65535, 1, 2, 24, 24};
    seg_rows[5] = $urandom_range(3, 60);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset height of 24 rows
    send_csi("", ChJ);                         // bare erase display always hits
    send_item(OpClrFlag, 8'h00, 16'h0000, 1'b0);
    send_item(OpSetRow, 8'h00, 16'd24, 1'b0);  // park on the status row
    send_csi("1", ChK);                        // erase-from-start on the last row
    send_csi("99999", ChF);                    // leading number saturates
    send_byte(ChEsc);                          // lone ESC: next byte seen as plain
    send_byte("E");
    send_item(OpUnused, 8'hFF, 16'hFFFF, 1'b1);
    send_csi("", ChB);                         // move down clamps onto the bottom row
    send_byte(ChLf);
    send_byte(8'h00);

    // Random part: idle mix goes sender-light, then receiver-light, then none
    for (int s = 0; s < NumSegments; s++) begin
      if (s < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 77;
      end else if (s < 5) begin
        send_idle_pct = 77;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_rows(16'(seg_rows[s]));
      target = items_sent + SegItems;
      while (items_sent < target) send_random_burst();
    end

    item_ch.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    while (reports_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
